// ----- design/llw_pkg.sv -----
package llw_pkg;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 16;
  localparam int TimeoutW  = 16;
  localparam int LqW       = 8;
  localparam int AgeOutW   = 16;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_CHAN  = 2'd1,
    ACT_STATS = 2'd2,
    ACT_NONE  = 2'd3
  } llw_action_t;

  typedef enum logic [2:0] {
    RSN_NONE        = 3'd0,
    RSN_NO_CHAN     = 3'd1,
    RSN_CHAN_STALE  = 3'd2,
    RSN_NO_STATS    = 3'd3,
    RSN_STATS_STALE = 3'd4,
    RSN_LOW_LQ      = 3'd5
  } llw_reason_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_CHAN_TIMEOUT  = 3'd0,
    CFG_STATS_TIMEOUT = 3'd1,
    CFG_LQ_LOST       = 3'd2,
    CFG_LQ_RECOVERED  = 3'd3,
    CFG_REQ_STATS     = 3'd4
  } llw_cfg_idx_t;

  localparam logic [TimeoutW-1:0] ChanTimeoutRst  = 16'd500;
  localparam logic [TimeoutW-1:0] StatsTimeoutRst = 16'd1000;
  localparam logic [LqW-1:0]      LqLostRst       = 8'd20;
  localparam logic [LqW-1:0]      LqRecoveredRst  = 8'd40;

  typedef struct packed {
    logic [TimeoutW-1:0] chan_timeout;
    logic [TimeoutW-1:0] stats_timeout;
    logic [LqW-1:0]      lq_lost;
    logic [LqW-1:0]      lq_recovered;
    logic                req_stats;
  } llw_cfg_t;

endpackage

// ----- design/llw_if.sv -----
interface llw_in_if
  import llw_pkg::*;
();

  logic           valid;
  logic           ready;
  logic [1:0]     action;
  logic [LqW-1:0] rx_quality;

  modport source (output valid, output action, output rx_quality, input ready);
  modport sink   (input valid, input action, input rx_quality, output ready);
endinterface

interface llw_out_if
  import llw_pkg::*;
();

  logic               valid;
  logic               ready;
  logic [2:0]         fault_code;
  logic               healthy;
  logic [AgeOutW-1:0] channels_age_ms;
  logic               channels_age_valid;
  logic [AgeOutW-1:0] stats_age_ms;
  logic               stats_age_valid;
  logic [LqW-1:0]     quality_now;
  logic               quality_ok;

  modport source (
    output valid, output fault_code, output healthy, output channels_age_ms,
    output channels_age_valid, output stats_age_ms, output stats_age_valid,
    output quality_now, output quality_ok, input ready
  );
  modport sink (
    input valid, input fault_code, input healthy, input channels_age_ms,
    input channels_age_valid, input stats_age_ms, input stats_age_valid,
    input quality_now, input quality_ok, output ready
  );
endinterface

// ----- design/llw_cfg_regs.sv -----
module llw_cfg_regs
  import llw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata,
  output llw_cfg_t             cfg
);

  llw_cfg_t cfg_r;
  llw_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CHAN_TIMEOUT:  cfg_nxt.chan_timeout  = cfg_wdata[TimeoutW-1:0];
        CFG_STATS_TIMEOUT: cfg_nxt.stats_timeout = cfg_wdata[TimeoutW-1:0];
        CFG_LQ_LOST:       cfg_nxt.lq_lost       = cfg_wdata[LqW-1:0];
        CFG_LQ_RECOVERED:  cfg_nxt.lq_recovered  = cfg_wdata[LqW-1:0];
        CFG_REQ_STATS:     cfg_nxt.req_stats     = cfg_wdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chan_timeout  <= ChanTimeoutRst;
      cfg_r.stats_timeout <= StatsTimeoutRst;
      cfg_r.lq_lost       <= LqLostRst;
      cfg_r.lq_recovered  <= LqRecoveredRst;
      cfg_r.req_stats     <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/link_loss_watchdog.sv -----
// Channel  Dir  Handshake        Payload
// in_ch    in   valid/ready      action, rx_quality
// out_ch   out  valid/ready      fault_code, healthy, ages, quality snapshot
// cfg      in   cfg_we only      cfg_index, cfg_wdata
//
// One word per cycle sustained while out_ch.ready is high; an accepted word passes the
// input register, then the result register, before its result turns valid on out_ch.
// Synchronous active-low reset clears the state and loads the register defaults.
// A stalled result holds the input register; in_ch.ready drops only when both
// stages are full and out_ch.ready is low.
module link_loss_watchdog
  import llw_pkg::*;
#(
  parameter int AGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  llw_in_if.sink               in_ch,
  llw_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata
);

  localparam int CmpW = (AGE_BITS > AgeOutW) ? AGE_BITS : AgeOutW;
  localparam logic [AGE_BITS-1:0] AgeMax = '1;
  localparam logic [CmpW-1:0] AgeOutMax = CmpW'({AgeOutW{1'b1}});

  llw_cfg_t cfg;

  llw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register
  logic           s1_valid_r;
  logic [1:0]     s1_action_r;
  logic [LqW-1:0] s1_lq_r;
  logic           s1_adv;
  logic           in_fire;

  // state
  logic                chan_seen_r, chan_seen_nxt;
  logic [AGE_BITS-1:0] chan_age_r, chan_age_nxt;
  logic                stats_seen_r, stats_seen_nxt;
  logic [AGE_BITS-1:0] stats_age_r, stats_age_nxt;
  logic [LqW-1:0]      lq_r, lq_nxt;
  logic                qok_r, qok_nxt;

  // result register
  logic               out_valid_r;
  llw_reason_t        reason_r, reason_nxt;
  logic [AgeOutW-1:0] chan_age_out_r, chan_age_out_nxt;
  logic [AgeOutW-1:0] stats_age_out_r, stats_age_out_nxt;

  logic [CmpW-1:0] chan_age_ext;
  logic [CmpW-1:0] stats_age_ext;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= in_ch.action;
      s1_lq_r     <= in_ch.rx_quality;
    end
  end

  always_comb begin
    chan_seen_nxt  = chan_seen_r;
    chan_age_nxt   = chan_age_r;
    stats_seen_nxt = stats_seen_r;
    stats_age_nxt  = stats_age_r;
    lq_nxt         = lq_r;
    qok_nxt        = qok_r;
    unique case (llw_action_t'(s1_action_r))
      ACT_TICK: begin
        if (chan_seen_r && chan_age_r != AgeMax) chan_age_nxt = chan_age_r + AGE_BITS'(1);
        if (stats_seen_r && stats_age_r != AgeMax) stats_age_nxt = stats_age_r + AGE_BITS'(1);
      end
      ACT_CHAN: begin
        chan_seen_nxt = 1'b1;
        chan_age_nxt  = '0;
      end
      ACT_STATS: begin
        stats_seen_nxt = 1'b1;
        stats_age_nxt  = '0;
        lq_nxt         = s1_lq_r;
        priority if (s1_lq_r < cfg.lq_lost) qok_nxt = 1'b0;
        else if (s1_lq_r >= cfg.lq_recovered) qok_nxt = 1'b1;
        else qok_nxt = qok_r;
      end
      ACT_NONE: ;
    endcase
  end

  assign chan_age_ext  = CmpW'(chan_age_nxt);
  assign stats_age_ext = CmpW'(stats_age_nxt);

  always_comb begin
    chan_age_out_nxt  = (chan_age_ext > AgeOutMax) ? AgeOutMax[AgeOutW-1:0]
                                                   : chan_age_ext[AgeOutW-1:0];
    stats_age_out_nxt = (stats_age_ext > AgeOutMax) ? AgeOutMax[AgeOutW-1:0]
                                                    : stats_age_ext[AgeOutW-1:0];
    priority if (!chan_seen_nxt)                              reason_nxt = RSN_NO_CHAN;
    else if (chan_age_ext > CmpW'(cfg.chan_timeout))          reason_nxt = RSN_CHAN_STALE;
    else if (!cfg.req_stats)                                  reason_nxt = RSN_NONE;
    else if (!stats_seen_nxt)                                 reason_nxt = RSN_NO_STATS;
    else if (stats_age_ext > CmpW'(cfg.stats_timeout))        reason_nxt = RSN_STATS_STALE;
    else if (!qok_nxt)                                        reason_nxt = RSN_LOW_LQ;
    else                                                      reason_nxt = RSN_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_seen_r  <= 1'b0;
      chan_age_r   <= '0;
      stats_seen_r <= 1'b0;
      stats_age_r  <= '0;
      lq_r         <= '0;
      qok_r        <= 1'b0;
    end else if (s1_valid_r && s1_adv) begin
      chan_seen_r  <= chan_seen_nxt;
      chan_age_r   <= chan_age_nxt;
      stats_seen_r <= stats_seen_nxt;
      stats_age_r  <= stats_age_nxt;
      lq_r         <= lq_nxt;
      qok_r        <= qok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      reason_r        <= reason_nxt;
      chan_age_out_r  <= chan_age_out_nxt;
      stats_age_out_r <= stats_age_out_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.fault_code         = reason_r;
  assign out_ch.healthy            = (reason_r == RSN_NONE);
  assign out_ch.channels_age_ms    = chan_age_out_r;
  assign out_ch.channels_age_valid = chan_seen_r;
  assign out_ch.stats_age_ms       = stats_age_out_r;
  assign out_ch.stats_age_valid    = stats_seen_r;
  assign out_ch.quality_now        = lq_r;
  assign out_ch.quality_ok         = qok_r;

  a_unseen_age_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !chan_seen_r |-> chan_age_r == '0)
    else $error("channel age moved before any channel word");

  a_qok_rise_on_stats: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(qok_r) |-> $past(s1_valid_r && s1_adv && s1_action_r == ACT_STATS))
    else $error("quality flag set without a stats word");

  a_low_lq_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && reason_r == RSN_LOW_LQ |-> !qok_r)
    else $error("low quality reported with flag set");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(chan_age_r) && $stable(stats_age_r))
    else $error("state advanced during output stall");

endmodule
